@@ rtl/core/sliding_window_rate_limiter_macros.svh @@
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_macros
// Assertion helpers for the rate limiter.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SWRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/swrl_pkg.sv @@
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared types and constants for the sliding window rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;
  localparam int TableEntriesDef = 64;
  localparam int RingSlotsDef    = 100;
  localparam int EventKindsDef   = 8;

  localparam logic [63:0] NsPerSecond    = 64'd1000000000;
  localparam logic [15:0] DefaultAgeSecs = 16'd3600;
  localparam logic [12:0] RemovedMax     = 13'd8191;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_RECORD  = 2'd1,
    OP_CLEANUP = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [2:0]  event_kind;
    logic [63:0] now_ns;
    logic [15:0] win_len_s;
    logic [15:0] evt_limit;
    logic [15:0] age_limit_s;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic [6:0]  hit_count;
    logic [12:0] removed_count;
    logic        status;
  } rsp_t;
endpackage

@@ rtl/core/swrl_if.sv @@
// ----------------------------------------------------------------------------
// swrl_req_if / swrl_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface swrl_req_if import swrl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swrl_rsp_if import swrl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/swrl_ram.sv @@
// ----------------------------------------------------------------------------
// swrl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/sliding_window_rate_limiter.sv @@
// Check/record scan the entry table (read, compare each entry; stop at a hit);
//   a check then walks its ring, reading and comparing each stored stamp.
// Cleanup: each valid entry has its stored stamps read and compared, then is
//   written back. One request in flight at a time.
// Reset clears the valid map (flip-flops) and the control state only.
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Rate limiter keeping per-client timestamp rings in an on-chip stamp RAM.
// ----------------------------------------------------------------------------
`include "sliding_window_rate_limiter_macros.svh"
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int RING_SLOTS    = RingSlotsDef,
  parameter int EVENT_KINDS   = EventKindsDef
) (
  input  logic clk,
  input  logic rst_n,
  swrl_req_if.sink   in_req,
  swrl_rsp_if.source out_rsp
);
  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW = $clog2(RING_SLOTS + 1);
  localparam int SD = TABLE_ENTRIES * RING_SLOTS;
  localparam int AW = $clog2(SD);
  localparam int KEYW = 131;
  localparam int EPW = KEYW + 2 * SW;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ERD   = 10'b0000000010,
    ST_ECMP  = 10'b0000000100,
    ST_SRD   = 10'b0000001000,
    ST_SCMP  = 10'b0000010000,
    ST_RECW  = 10'b0000100000,
    ST_CRD   = 10'b0001000000,
    ST_CCMP  = 10'b0010000000,
    ST_CEND  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state_r;
  req_t   req_r;
  rsp_t   rsp_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [EW-1:0] eidx_r;
  logic [SW-1:0] ridx_r, widx_r, fill_r, oldp_r;
  logic          hit_r, free_found_r;
  logic [EW-1:0] free_r;
  logic [63:0]   thr_r;
  logic [12:0]   rem_r;
  logic [AW-1:0] base_r;

  // entry RAM: key, fill, oldest pointer
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [EPW-1:0] e_wdata, e_rdata;
  swrl_ram #(.Width(EPW), .Depth(TABLE_ENTRIES)) u_ent (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr),
    .rdata(e_rdata));

  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [63:0]   s_wdata, s_rdata;
  swrl_ram #(.Width(64), .Depth(SD)) u_stamp (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
    .rdata(s_rdata));

  logic [KEYW-1:0] key_in, key_rd;
  logic [SW-1:0]   fill_rd, oldp_rd, fill_c;
  logic            kind_ok, last_e;
  assign key_in  = {req_r.address_high, req_r.address_low, req_r.event_kind};
  assign key_rd  = e_rdata[EPW-1 -: KEYW];
  assign fill_rd = e_rdata[2*SW-1:SW];
  assign oldp_rd = e_rdata[SW-1:0];
  assign fill_c  = (fill_rd > SW'(RING_SLOTS)) ? SW'(RING_SLOTS) : fill_rd;
  assign kind_ok = 32'(req_r.event_kind) < EVENT_KINDS;
  assign last_e  = 32'(eidx_r) == TABLE_ENTRIES - 1;

  assign in_req.ready  = state_r == ST_IDLE;
  assign out_rsp.valid = state_r == ST_OUT;
  assign out_rsp.data  = rsp_r;

  // threshold: now - secs * 1e9
  logic [15:0] secs_sel;
  always_comb begin
    secs_sel = in_req.data.win_len_s;
    if (in_req.data.opcode == OP_CLEANUP) begin
      secs_sel = (in_req.data.age_limit_s == '0) ? DefaultAgeSecs
                                                : in_req.data.age_limit_s;
    end
  end

  // memory port control
  always_comb begin
    e_we = 1'b0; e_waddr = eidx_r; e_wdata = '0; e_raddr = eidx_r;
    s_we = 1'b0; s_waddr = base_r + AW'(widx_r); s_wdata = s_rdata;
    s_raddr = base_r + AW'(ridx_r);
    unique case (state_r)
      ST_RECW: begin
        s_we = hit_r || free_found_r;
        e_we = s_we;
        e_waddr = eidx_r;
        if (fill_r < SW'(RING_SLOTS)) begin
          s_waddr = base_r + AW'(fill_r);
          e_wdata = {key_in, fill_r + SW'(1), oldp_r};
        end else begin
          s_waddr = base_r + AW'(oldp_r);
          e_wdata = {key_in, fill_r,
                     (32'(oldp_r) + 1 >= RING_SLOTS) ? SW'(0) : oldp_r + SW'(1)};
        end
        s_wdata = req_r.now_ns;
      end
      ST_CCMP: begin
        s_we = s_rdata >= thr_r;
      end
      ST_CEND: begin
        e_we = 1'b1;
        e_wdata = {key_rd, widx_r, SW'(0)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_req.valid) begin
          req_r  <= in_req.data;
          thr_r  <= in_req.data.now_ns - 64'(secs_sel) * NsPerSecond;
          eidx_r <= '0;
          hit_r  <= 1'b0;
          free_found_r <= 1'b0;
          rsp_r  <= '0;
          rem_r  <= '0;
          state_r <= ST_ERD;
        end
        ST_ERD: state_r <= ST_ECMP;
        ST_ECMP: begin
          ridx_r <= '0;
          widx_r <= '0;
          base_r <= AW'(eidx_r * RING_SLOTS);
          fill_r <= fill_c;
          oldp_r <= (32'(oldp_rd) >= RING_SLOTS) ? SW'(0) : oldp_rd;
          if (req_r.opcode == OP_CLEANUP) begin
            if (valid_r[eidx_r] && fill_c != '0) state_r <= ST_CRD;
            else if (valid_r[eidx_r]) state_r <= ST_CEND;
            else if (last_e) begin
              rsp_r.removed_count <= rem_r;
              state_r <= ST_OUT;
            end
            else begin eidx_r <= eidx_r + EW'(1); state_r <= ST_ERD; end
          end else if (req_r.opcode == OP_NONE || !kind_ok) begin
            state_r <= ST_OUT;
          end else if (valid_r[eidx_r] && key_rd == key_in) begin
            hit_r <= 1'b1;
            if (req_r.opcode == OP_RECORD) state_r <= ST_RECW;
            else if (fill_c == '0) begin
              rsp_r.allowed <= 16'd0 < req_r.evt_limit; state_r <= ST_OUT;
            end else state_r <= ST_SRD;
          end else begin
            if (!valid_r[eidx_r] && !free_found_r) begin
              free_found_r <= 1'b1;
              free_r <= eidx_r;
            end
            if (last_e) begin
              if (req_r.opcode == OP_CHECK) begin
                rsp_r.allowed <= 16'd0 < req_r.evt_limit;
                state_r <= ST_OUT;
              end else if (free_found_r || !valid_r[eidx_r]) begin
                eidx_r <= (free_found_r) ? free_r : eidx_r;
                base_r <= AW'(((free_found_r) ? free_r : eidx_r) * RING_SLOTS);
                fill_r <= '0;
                oldp_r <= '0;
                state_r <= ST_RECW;
              end else begin
                rsp_r.status <= 1'b1;
                state_r <= ST_OUT;
              end
            end else begin
              eidx_r <= eidx_r + EW'(1);
              state_r <= ST_ERD;
            end
          end
        end
        ST_SRD: state_r <= ST_SCMP;
        ST_SCMP: begin
          if (s_rdata >= thr_r) widx_r <= widx_r + SW'(1);
          if (ridx_r + SW'(1) == fill_r) begin
            rsp_r.hit_count <= 7'((s_rdata >= thr_r) ? widx_r + SW'(1) : widx_r);
            rsp_r.allowed <= 16'((s_rdata >= thr_r) ? widx_r + SW'(1) : widx_r)
                             < req_r.evt_limit;
            state_r <= ST_OUT;
          end else begin
            ridx_r <= ridx_r + SW'(1);
            state_r <= ST_SRD;
          end
        end
        ST_RECW: begin
          valid_r[eidx_r] <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_CRD: state_r <= ST_CCMP;
        ST_CCMP: begin
          if (s_rdata >= thr_r) widx_r <= widx_r + SW'(1);
          else if (rem_r != RemovedMax) rem_r <= rem_r + 13'd1;
          // entry read data still holds this entry's key for the write-back
          if (ridx_r + SW'(1) == fill_r) begin
            state_r <= ST_CEND;
          end else begin
            ridx_r <= ridx_r + SW'(1);
            state_r <= ST_CRD;
          end
        end
        ST_CEND: begin
          if (widx_r == '0) valid_r[eidx_r] <= 1'b0;
          if (last_e) begin
            rsp_r.removed_count <= rem_r;
            state_r <= ST_OUT;
          end else begin
            eidx_r <= eidx_r + EW'(1);
            state_r <= ST_ERD;
          end
        end
        ST_OUT: if (out_rsp.ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SWRL_ASSERT_IMP(a_ready_idle, in_req.ready, state_r == ST_IDLE, "ready outside idle")
  `SWRL_ASSERT_NEXT(a_take, in_req.valid && in_req.ready, state_r == ST_ERD, "lookup not started")
  `SWRL_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r), "state not one-hot")
endmodule

@@ dv/sliding_window_rate_limiter_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_chk
// Watches the request and result channels, tracks the client table and the
// timestamp rings on its own, and compares every result beat with the
// expected one in order. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_chk import swrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req_data,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp_data,
  output int         fail_count,
  output int         pending_count
);
  localparam int Entries = TableEntriesDef;
  localparam int Slots   = RingSlotsDef;
  localparam int Kinds   = EventKindsDef;

  // client table image
  logic        tbl_valid [Entries];
  logic [63:0] tbl_hi    [Entries];
  logic [63:0] tbl_lo    [Entries];
  logic [2:0]  tbl_kind  [Entries];
  int          tbl_fill  [Entries];
  int          tbl_old   [Entries];
  logic [63:0] stamps    [Entries][Slots];

  rsp_t expected_rsp_q[$];

  assign pending_count = expected_rsp_q.size();

  function automatic int find_client(input req_t r);
    for (int e = 0; e < Entries; e++)
      if (tbl_valid[e] && tbl_hi[e] == r.address_high && tbl_lo[e] == r.address_low &&
          tbl_kind[e] == r.event_kind)
        return e;
    return -1;
  endfunction

  // apply one request to the table image and return the expected result
  function automatic rsp_t limiter_step(input req_t r);
    rsp_t        res;
    int          e;
    int          w;
    int          removed;
    logic [63:0] start;
    logic [63:0] secs;
    res = '0;
    removed = 0;
    if (r.opcode == OP_CHECK && int'(r.event_kind) < Kinds) begin
      start = r.now_ns - 64'(r.win_len_s) * NsPerSecond;
      e = find_client(r);
      if (e >= 0) begin
        for (int i = 0; i < tbl_fill[e]; i++)
          if (stamps[e][i] >= start) res.hit_count++;
      end
      res.allowed = (16'(res.hit_count) < r.evt_limit);
    end else if (r.opcode == OP_RECORD && int'(r.event_kind) < Kinds) begin
      e = find_client(r);
      if (e < 0) begin
        for (int k = 0; k < Entries; k++)
          if (!tbl_valid[k]) begin
            e = k;
            break;
          end
        if (e >= 0) begin
          tbl_valid[e] = 1'b1;
          tbl_hi[e] = r.address_high;
          tbl_lo[e] = r.address_low;
          tbl_kind[e] = r.event_kind;
          tbl_fill[e] = 0;
          tbl_old[e] = 0;
        end
      end
      if (e < 0) begin
        res.status = 1'b1;
      end else if (tbl_fill[e] < Slots) begin
        stamps[e][tbl_fill[e]] = r.now_ns;
        tbl_fill[e]++;
      end else begin
        stamps[e][tbl_old[e]] = r.now_ns;
        tbl_old[e] = (tbl_old[e] + 1) % Slots;
      end
    end else if (r.opcode == OP_CLEANUP) begin
      secs = (r.age_limit_s != 0) ? 64'(r.age_limit_s) : 64'(DefaultAgeSecs);
      start = r.now_ns - secs * NsPerSecond;
      for (int k = 0; k < Entries; k++) begin
        if (!tbl_valid[k]) continue;
        w = 0;
        for (int i = 0; i < tbl_fill[k]; i++)
          if (stamps[k][i] >= start) begin
            stamps[k][w] = stamps[k][i];
            w++;
          end
        removed += tbl_fill[k] - w;
        tbl_fill[k] = w;
        tbl_old[k] = 0;
        if (w == 0) tbl_valid[k] = 1'b0;
      end
      res.removed_count = (removed > int'(RemovedMax)) ? RemovedMax : 13'(removed);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // track beats on both channels
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int e = 0; e < Entries; e++) begin
        tbl_valid[e] = 1'b0;
        tbl_fill[e] = 0;
        tbl_old[e] = 0;
      end
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result beat with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_data.allowed !== want.allowed)
            report_mismatch("allowed", int'(rsp_data.allowed), int'(want.allowed));
          if (rsp_data.hit_count !== want.hit_count)
            report_mismatch("hit_count", int'(rsp_data.hit_count), int'(want.hit_count));
          if (rsp_data.removed_count !== want.removed_count)
            report_mismatch("removed_count", int'(rsp_data.removed_count),
                            int'(want.removed_count));
          if (rsp_data.status !== want.status)
            report_mismatch("status", int'(rsp_data.status), int'(want.status));
        end
      end
      if (req_valid && req_ready)
        expected_rsp_q.push_back(limiter_step(req_data));
    end
  end
endmodule

@@ dv/sliding_window_rate_limiter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_tb
// Drives check, record and cleanup requests from a small pool of clients with
// random gaps and result stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_tb;
  import swrl_pkg::*;

  localparam int RandomItems = 1770;
  // worst request: full cleanup walk plus both idle draws
  localparam int ItemBudget  = TableEntriesDef * (2 * RingSlotsDef + 3) + 40;
  localparam int CycleLimit  = 3 * (RandomItems + 300) * ItemBudget;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   cycle_count;

  swrl_req_if req_if ();
  swrl_rsp_if rsp_if ();

  sliding_window_rate_limiter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if.sink),
    .out_rsp(rsp_if.source)
  );

  sliding_window_rate_limiter_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_if.valid),
    .req_ready    (req_if.ready),
    .req_data     (req_if.data),
    .rsp_valid    (rsp_if.valid),
    .rsp_ready    (rsp_if.ready),
    .rsp_data     (rsp_if.data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random stall before each beat
  initial begin
    int wait_cycles;
    rsp_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      wait_cycles = $urandom_range(0, 16);
      repeat (wait_cycles) @(posedge clk);
      rsp_if.ready <= 1'b1;
      @(posedge clk iff rsp_if.valid);
      rsp_if.ready <= 1'b0;
    end
  end

  // small pool of client addresses so entries are revisited
  logic [63:0] pool_hi [8];
  logic [63:0] pool_lo [8];
  logic [63:0] clock_ns;

  task automatic send_beat(input req_t r);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.data  <= r;
    req_if.valid <= 1'b1;
    @(posedge clk iff req_if.ready);
  endtask

  task automatic idle_source();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t client_req(input opcode_t op, input int c, input logic [2:0] k);
    req_t r;
    r = '0;
    r.opcode       = op;
    r.address_high = pool_hi[c];
    r.address_low  = pool_lo[c];
    r.event_kind   = k;
    r.now_ns       = clock_ns;
    r.win_len_s    = 16'($urandom_range(0, 40));
    r.evt_limit    = 16'($urandom_range(0, 110));
    r.age_limit_s  = 16'($urandom_range(0, 40));
    return r;
  endfunction

  initial begin
    req_t r;
    int   pick;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_n = 1'b0;
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = (i == 0) ? 64'd0 : (i == 1) ? '1 : rand64();
      pool_lo[i] = (i == 0) ? 64'd0 : (i == 1) ? '1 : rand64();
    end
    clock_ns = 64'd5_000_000_000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty check, extremes, ring wrap, every opcode
    r = client_req(OP_CHECK, 0, 3'd0);
    send_beat(r);
    r = client_req(OP_RECORD, 1, 3'd7);
    r.now_ns = '1;
    send_beat(r);
    r = client_req(OP_CHECK, 1, 3'd7);
    r.now_ns = '1; r.win_len_s = 16'hFFFF; r.evt_limit = 16'hFFFF;
    send_beat(r);
    r = client_req(OP_CHECK, 1, 3'd7);
    r.evt_limit = 16'd0;
    send_beat(r);
    r = client_req(OP_NONE, 0, 3'd0);
    r.now_ns = rand64();
    send_beat(r);
    // fill one ring past its size so the oldest stamps are overwritten
    for (int i = 0; i < 105; i++) begin
      clock_ns += 64'd100_000_000;
      send_beat(client_req(OP_RECORD, 0, 3'd2));
    end
    r = client_req(OP_CHECK, 0, 3'd2);
    r.win_len_s = 16'd5; r.evt_limit = 16'd101;
    send_beat(r);
    r = client_req(OP_CLEANUP, 0, 3'd0);
    r.age_limit_s = 16'd0;
    send_beat(r);
    r = client_req(OP_CLEANUP, 0, 3'd0);
    r.age_limit_s = 16'hFFFF; r.now_ns = 64'd0;
    send_beat(r);
    // table full: 64 distinct clients then one more
    for (int i = 0; i < 65; i++) begin
      r = client_req(OP_RECORD, 2, 3'(i));
      r.address_low = 64'(i) << 8;
      send_beat(r);
    end
    r = client_req(OP_CLEANUP, 0, 3'd0);
    r.age_limit_s = 16'd1; r.now_ns = clock_ns + 64'd10_000_000_000;
    send_beat(r);

    // hold off until every result is back
    idle_source();
    while (pending_count != 0) @(posedge clk);

    // random traffic
    for (int n = 0; n < RandomItems; n++) begin
      clock_ns += 64'($urandom_range(0, 2000)) * 64'd1_000_000;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = client_req(OP_RECORD, $urandom_range(0, 7), 3'($urandom_range(0, 3)));
      end else if (pick < 90) begin
        r = client_req(OP_CHECK, $urandom_range(0, 7), 3'($urandom_range(0, 3)));
      end else if (pick < 95) begin
        r = client_req(OP_CLEANUP, 0, 3'd0);
      end else begin
        r = client_req(opcode_t'($urandom_range(0, 3)), 0, 3'($urandom_range(0, 7)));
        r.address_high = rand64();
        r.address_low  = rand64();
        r.now_ns       = rand64();
        r.win_len_s    = 16'($urandom);
        r.evt_limit    = 16'($urandom);
        r.age_limit_s  = 16'($urandom);
      end
      send_beat(r);
    end
    idle_source();

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sliding_window_rate_limiter.f @@
+incdir+rtl/core
rtl/core/swrl_pkg.sv
rtl/core/swrl_if.sv
rtl/core/swrl_ram.sv
rtl/core/sliding_window_rate_limiter.sv
dv/sliding_window_rate_limiter_chk.sv
dv/sliding_window_rate_limiter_tb.sv
